// ===== src/oops_pkg.sv =====
// ----------------------------------------------------------------------------
// Odd-only prime sieve package
// Item types, fixed field widths, step codes and the control store of the
// microcoded sequencer.
// ----------------------------------------------------------------------------
package oops_pkg;

    localparam int LIMIT_W = 16;
    localparam int INDEX_W = 13;
    localparam int COUNT_W = 14;
    localparam int VALUE_W = 16;
    localparam int LIMIT_TOP = 65535;
    localparam int INDEX_SPAN = 8192;
    localparam int P_W = 9;
    localparam int PP_W = 18;
    localparam int M_W = 17;
    localparam int STEP_W = 5;
    localparam int FIRST_ODD_PRIME = 3;
    localparam int EVEN_PRIME = 2;

    localparam logic MODE_SIEVE   = 1'b0;
    localparam logic MODE_READ    = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [LIMIT_W-1:0] limit;
        logic [INDEX_W-1:0] index;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] prime_count;
        logic [VALUE_W-1:0] prime_value;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_INIT,
        OP_FILL,
        OP_RDP,
        OP_MINIT,
        OP_STRIKE,
        OP_PNEXT,
        OP_CINIT,
        OP_CRD,
        OP_CPUT,
        OP_SETCNT,
        OP_ZERO,
        OP_SIEVE_RES,
        OP_RDL,
        OP_READ_RES,
        OP_BAD_RES
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_MODE_READ,
        C_LOW_LIMIT,
        C_K_MORE,
        C_PP_GT_N,
        C_FLAG_CLR,
        C_M_LE_N,
        C_SCAN_EMPTY,
        C_IDX_BAD
    } t_csel;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_IDLE    = 5'd0;
    localparam t_step S_KIND    = 5'd1;
    localparam t_step S_INIT    = 5'd2;
    localparam t_step S_FILL    = 5'd3;
    localparam t_step S_PLOOP   = 5'd4;
    localparam t_step S_PTEST   = 5'd5;
    localparam t_step S_STRIKE  = 5'd6;
    localparam t_step S_PNEXT   = 5'd7;
    localparam t_step S_COLLECT = 5'd8;
    localparam t_step S_CRD     = 5'd9;
    localparam t_step S_CPUT    = 5'd10;
    localparam t_step S_FIN     = 5'd11;
    localparam t_step S_DONE    = 5'd12;
    localparam t_step S_SMALL   = 5'd13;
    localparam t_step S_READ    = 5'd14;
    localparam t_step S_RDONE   = 5'd15;
    localparam t_step S_BAD     = 5'd16;

    typedef struct packed {
        t_op   op;
        t_csel csel;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic no_start;
        logic mode_read;
        logic low_limit;
        logic k_more;
        logic pp_gt_n;
        logic flag_clr;
        logic m_le_n;
        logic scan_empty;
        logic idx_bad;
    } t_cond;

    typedef struct packed {
        t_op  op;
        logic busy;
    } t_ctrl;

    // A taken condition jumps to the target; otherwise the next step follows.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            S_IDLE:    w = '{OP_LATCH,     C_NO_START,   S_IDLE};
            S_KIND:    w = '{OP_NOP,       C_MODE_READ,  S_READ};
            S_INIT:    w = '{OP_INIT,      C_LOW_LIMIT,  S_SMALL};
            S_FILL:    w = '{OP_FILL,      C_K_MORE,     S_FILL};
            S_PLOOP:   w = '{OP_RDP,       C_PP_GT_N,    S_COLLECT};
            S_PTEST:   w = '{OP_MINIT,     C_FLAG_CLR,   S_PNEXT};
            S_STRIKE:  w = '{OP_STRIKE,    C_M_LE_N,     S_STRIKE};
            S_PNEXT:   w = '{OP_PNEXT,     C_ALWAYS,     S_PLOOP};
            S_COLLECT: w = '{OP_CINIT,     C_SCAN_EMPTY, S_FIN};
            S_CRD:     w = '{OP_CRD,       C_NEVER,      S_IDLE};
            S_CPUT:    w = '{OP_CPUT,      C_K_MORE,     S_CRD};
            S_FIN:     w = '{OP_SETCNT,    C_NEVER,      S_IDLE};
            S_DONE:    w = '{OP_SIEVE_RES, C_ALWAYS,     S_IDLE};
            S_SMALL:   w = '{OP_ZERO,      C_ALWAYS,     S_DONE};
            S_READ:    w = '{OP_RDL,       C_IDX_BAD,    S_BAD};
            S_RDONE:   w = '{OP_READ_RES,  C_ALWAYS,     S_IDLE};
            S_BAD:     w = '{OP_BAD_RES,   C_ALWAYS,     S_IDLE};
            default:   w = '{OP_NOP,       C_ALWAYS,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== src/oops_seq.sv =====
// ----------------------------------------------------------------------------
// Odd-only prime sieve sequencer
// Step counter over the control store, with conditional jumps on datapath
// status.
// ----------------------------------------------------------------------------
module oops_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  oops_pkg::t_cond  i_cond,
    output oops_pkg::t_ctrl  o_ctrl
);

    oops_pkg::t_step  r_step;
    oops_pkg::t_step  n_step;
    oops_pkg::t_uword uword;
    logic             take;

    assign uword = oops_pkg::ucode(r_step);

    always_comb begin
        unique case (uword.csel)
            oops_pkg::C_NEVER:      take = 1'b0;
            oops_pkg::C_ALWAYS:     take = 1'b1;
            oops_pkg::C_NO_START:   take = i_cond.no_start;
            oops_pkg::C_MODE_READ:  take = i_cond.mode_read;
            oops_pkg::C_LOW_LIMIT:  take = i_cond.low_limit;
            oops_pkg::C_K_MORE:     take = i_cond.k_more;
            oops_pkg::C_PP_GT_N:    take = i_cond.pp_gt_n;
            oops_pkg::C_FLAG_CLR:   take = i_cond.flag_clr;
            oops_pkg::C_M_LE_N:     take = i_cond.m_le_n;
            oops_pkg::C_SCAN_EMPTY: take = i_cond.scan_empty;
            oops_pkg::C_IDX_BAD:    take = i_cond.idx_bad;
            default:                take = 1'b1;
        endcase
        n_step = take ? uword.target : oops_pkg::t_step'(r_step + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= oops_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.op   = uword.op;
    assign o_ctrl.busy = (r_step != oops_pkg::S_IDLE);

endmodule

// ===== src/odd_only_prime_sieve.sv =====
// ----------------------------------------------------------------------------
// Odd-only prime sieve
// Sieve of Eratosthenes over odd numbers with a readable prime list, run by a
// microcoded sequencer over a flag memory and a list memory.
//
//  channel   handshake            payload
//  input     start, busy          i_item   (mode, limit, index)
//  result    o_done (one cycle)   o_result (status, prime_count, prime_value)
//
// A sieve item fills the flag memory over the odd numbers up to n, strikes the
// odd multiples of each odd prime p with p*p <= n, skips each odd composite p,
// and then scans the odd numbers to collect the list; all flag reads and
// writes share the single-port flag memory.
// A read item goes from its kind step through a list read to its result.
// Reset clears the sequencer, the prime count and the result strobe only; no
// clearing pass runs. The result strobe comes in the cycle after the last step
// and cannot be stalled.
module odd_only_prime_sieve #(
    parameter int MAX_LIMIT  = 65535,
    parameter int LIST_DEPTH = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  oops_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_done,
    output oops_pkg::t_out_item  o_result
);

    localparam int EFF_LIMIT  = (MAX_LIMIT < oops_pkg::LIMIT_TOP) ? MAX_LIMIT
                                                                  : oops_pkg::LIMIT_TOP;
    localparam int FLAG_DEPTH = EFF_LIMIT / 2 + 1;
    localparam int FW         = $clog2(FLAG_DEPTH);
    localparam int KW         = FW + 1;
    localparam int LIST_USE   = (LIST_DEPTH < oops_pkg::INDEX_SPAN) ? LIST_DEPTH
                                                                    : oops_pkg::INDEX_SPAN;
    localparam int LW         = (LIST_USE > 1) ? $clog2(LIST_USE) : 1;
    localparam int NW         = oops_pkg::LIMIT_W;
    localparam int CW         = oops_pkg::COUNT_W;
    localparam int VW         = oops_pkg::VALUE_W;
    localparam int IW         = oops_pkg::INDEX_W;
    localparam int PW         = oops_pkg::P_W;
    localparam int QW         = oops_pkg::PP_W;
    localparam int MW         = oops_pkg::M_W;

    localparam logic [NW-1:0] SAT_N    = NW'(EFF_LIMIT);
    localparam logic [CW-1:0] LIST_CAP = CW'(LIST_USE);

    oops_pkg::t_ctrl ctrl;
    oops_pkg::t_cond cond;

    logic          r_mode, n_mode;
    logic [NW-1:0] r_n, n_n;
    logic [IW-1:0] r_idx, n_idx;
    logic [KW-1:0] r_k, n_k;
    logic [PW-1:0] r_p, n_p;
    logic [QW-1:0] r_pp, n_pp;
    logic [MW-1:0] r_m, n_m;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_count, n_count;
    logic          r_done, n_done;
    oops_pkg::t_out_item r_res, n_res;

    logic          r_flag_mem [FLAG_DEPTH];
    logic          r_fl_q;
    logic          fl_we, fl_re, fl_wd;
    logic [FW-1:0] fl_addr;

    logic [VW-1:0] r_list_mem [LIST_USE];
    logic [VW-1:0] r_li_q;
    logic          li_we, li_re;
    logic [LW-1:0] li_addr;
    logic [VW-1:0] li_wd;

    logic [KW-1:0] odds;
    logic [KW-1:0] k_inc;

    assign odds  = KW'(({1'b0, r_n} + 17'd1) >> 1);
    assign k_inc = r_k + KW'(1);

    assign cond.no_start   = !start;
    assign cond.mode_read  = (r_mode == oops_pkg::MODE_READ);
    assign cond.low_limit  = (r_n < NW'(oops_pkg::EVEN_PRIME));
    assign cond.k_more     = (k_inc < odds);
    assign cond.pp_gt_n    = (r_pp > QW'(r_n));
    assign cond.flag_clr   = !r_fl_q;
    assign cond.m_le_n     = (r_m <= MW'(r_n));
    assign cond.scan_empty = (odds <= KW'(1));
    assign cond.idx_bad    = (CW'(r_idx) >= r_count);

    oops_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl)
    );

    always_comb begin
        n_mode  = r_mode;
        n_n     = r_n;
        n_idx   = r_idx;
        n_k     = r_k;
        n_p     = r_p;
        n_pp    = r_pp;
        n_m     = r_m;
        n_cnt   = r_cnt;
        n_count = r_count;
        n_done  = 1'b0;
        n_res   = r_res;
        fl_we   = 1'b0;
        fl_re   = 1'b0;
        fl_wd   = 1'b0;
        fl_addr = r_k[FW-1:0];
        li_we   = 1'b0;
        li_re   = 1'b0;
        li_addr = LW'(r_cnt);
        li_wd   = VW'(oops_pkg::EVEN_PRIME);
        unique case (ctrl.op)
            oops_pkg::OP_NOP: begin
            end
            oops_pkg::OP_LATCH: begin
                if (start) begin
                    n_mode = i_item.mode;
                    n_n    = (i_item.limit > SAT_N) ? SAT_N : i_item.limit;
                    n_idx  = i_item.index;
                end
            end
            oops_pkg::OP_INIT: begin
                n_k  = '0;
                n_p  = PW'(oops_pkg::FIRST_ODD_PRIME);
                n_pp = QW'(oops_pkg::FIRST_ODD_PRIME * oops_pkg::FIRST_ODD_PRIME);
            end
            oops_pkg::OP_FILL: begin
                fl_we = 1'b1;
                fl_wd = |r_k;
                n_k   = k_inc;
            end
            oops_pkg::OP_RDP: begin
                fl_re   = !cond.pp_gt_n;
                fl_addr = FW'(r_p >> 1);
            end
            oops_pkg::OP_MINIT: begin
                n_m = MW'(r_pp);
            end
            oops_pkg::OP_STRIKE: begin
                fl_we   = cond.m_le_n;
                fl_addr = FW'(r_m >> 1);
                n_m     = r_m + MW'({r_p, 1'b0});
            end
            oops_pkg::OP_PNEXT: begin
                n_p  = r_p + PW'(2);
                n_pp = r_pp + QW'({r_p, 2'b00}) + QW'(4);
            end
            oops_pkg::OP_CINIT: begin
                li_we   = 1'b1;
                li_addr = '0;
                n_cnt   = CW'(1);
                n_k     = KW'(1);
            end
            oops_pkg::OP_CRD: begin
                fl_re = 1'b1;
            end
            oops_pkg::OP_CPUT: begin
                if (r_fl_q && (r_cnt < LIST_CAP)) begin
                    li_we = 1'b1;
                    li_wd = VW'({r_k, 1'b1});
                    n_cnt = r_cnt + CW'(1);
                end
                n_k = k_inc;
            end
            oops_pkg::OP_SETCNT: begin
                n_count = r_cnt;
            end
            oops_pkg::OP_ZERO: begin
                n_count = '0;
            end
            oops_pkg::OP_SIEVE_RES: begin
                n_done = 1'b1;
                n_res  = '{status: oops_pkg::STATUS_OK, prime_count: r_count,
                           prime_value: '0};
            end
            oops_pkg::OP_RDL: begin
                li_re   = !cond.idx_bad;
                li_addr = LW'(r_idx);
            end
            oops_pkg::OP_READ_RES: begin
                n_done = 1'b1;
                n_res  = '{status: oops_pkg::STATUS_OK, prime_count: r_count,
                           prime_value: r_li_q};
            end
            oops_pkg::OP_BAD_RES: begin
                n_done = 1'b1;
                n_res  = '{status: oops_pkg::STATUS_RANGE, prime_count: r_count,
                           prime_value: '0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_n    <= n_n;
        r_idx  <= n_idx;
        r_k    <= n_k;
        r_p    <= n_p;
        r_pp   <= n_pp;
        r_m    <= n_m;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            r_flag_mem[fl_addr] <= fl_wd;
        end
        if (fl_re) begin
            r_fl_q <= r_flag_mem[fl_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (li_we) begin
            r_list_mem[li_addr] <= li_wd;
        end
        if (li_re) begin
            r_li_q <= r_list_mem[li_addr];
        end
    end

    assign busy     = ctrl.busy;
    assign o_done   = r_done;
    assign o_result = r_res;

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status) |-> (o_result.prime_value == '0))
        else $error("Error result carries a nonzero prime value.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted item did not make the block busy.");

    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("Two results in consecutive cycles.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("Result shown while an item is still in work.");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LIST_CAP)
        else $error("Prime count above list capacity.");

endmodule
